// ----- rtl/core/ma_q16_pkg.sv -----
// package for the q16 moving average block
// holds sizes, the controller state type and the command and status structs
// no dependencies
package ma_q16_pkg;

	localparam int WINDOW   = 5;
	localparam int SAMPLE_W = 16;
	localparam int FRAC_W   = 16;
	localparam int AVG_W    = 32;
	localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW + 1);
	localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W    = $clog2(WINDOW + 1);
	localparam int DIV_W    = SUM_W + FRAC_W;
	localparam int STEP_W   = $clog2(DIV_W);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOAD = 5'b00010,
		ST_PREP = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_FIN  = 5'b10000
	} maq16_state_t;

	typedef struct packed {
		logic take;
		logic update;
		logic prep;
		logic step;
		logic finish;
	} maq16_cmd_t;

	typedef struct packed {
		logic div_last;
		logic out_free;
	} maq16_sts_t;

endpackage

// ----- rtl/core/maq16_if.sv -----
// request channels of the q16 moving average block
// depends on ma_q16_pkg for the field widths
interface maq16_sample_if import ma_q16_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

interface maq16_avg_if import ma_q16_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [AVG_W-1:0] average;

	modport source(output valid, output average, input ready);
	modport sink(input valid, input average, output ready);
endinterface

// ----- rtl/core/moving_average_q16_unit.sv -----
// top level of the q16 moving average block
// depends on ma_q16_pkg, maq16_if, maq16_ctrl and maq16_dp
//
// Takes one signed 16-bit sample per request and returns one signed Q16.16
// mean of the last WINDOW samples (fewer while the window is still filling),
// truncated toward zero. One sample is worked on at a time: after acceptance the
// ring and running sum are updated, the dividend is prepared, the restoring
// divider produces one quotient bit per cycle and the result register is then
// loaded, waiting while an earlier average is still untaken. The next sample
// can be accepted once the controller is back in idle; the result register
// lets it be accepted while a finished average still waits to be taken.
module moving_average_q16_unit import ma_q16_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	maq16_sample_if.sink       samples,
	maq16_avg_if.source        averages
);

	maq16_cmd_t cmd;
	maq16_sts_t sts;

	maq16_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(samples.valid),
		.in_ready(samples.ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	maq16_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.sample   (samples.sample),
		.avg_valid(averages.valid),
		.avg_ready(averages.ready),
		.average  (averages.average)
	);

endmodule

// ----- rtl/core/maq16_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module maq16_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 5
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/maq16_ctrl.sv -----
// controller state machine of the q16 moving average block
// depends on ma_q16_pkg for the state type and command and status structs
module maq16_ctrl import ma_q16_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  maq16_sts_t sts,
	output maq16_cmd_t cmd
);

	maq16_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take  = 1'b1;
					state_nxt = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.update = 1'b1;
				state_nxt  = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep  = 1'b1;
				state_nxt = ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (sts.div_last) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/core/maq16_dp.sv -----
// datapath of the q16 moving average block: ring, running sum, divider, output register
// depends on ma_q16_pkg and maq16_ram
module maq16_dp import ma_q16_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  maq16_cmd_t                 cmd,
	output maq16_sts_t                 sts,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       avg_valid,
	input  logic                       avg_ready,
	output logic signed [AVG_W-1:0]    average
);

	logic signed [SAMPLE_W-1:0] sample_q;
	logic [SAMPLE_W-1:0]        old_rd;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SUM_W-1:0]    sub_v;
	logic signed [SUM_W-1:0]    sum_nxt;
	logic [SUM_W-1:0]           mag;
	logic [SLOT_W-1:0]          slot_q;
	logic [CNT_W-1:0]           count_q;
	logic                       full;
	logic                       neg_q;
	logic [DIV_W-1:0]           dvd_q;
	logic [DIV_W-1:0]           quo_res;
	logic [CNT_W-1:0]           rem_q;
	logic [CNT_W:0]             trial;
	logic [CNT_W:0]             diff;
	logic                       ge;
	logic [STEP_W-1:0]          step_q;
	logic                       out_valid_q;
	logic signed [AVG_W-1:0]    avg_q;

	maq16_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (cmd.update),
		.waddr(slot_q),
		.wdata(sample_q),
		.re   (cmd.take),
		.raddr(slot_q),
		.rdata(old_rd)
	);

	assign full    = (count_q == CNT_W'(WINDOW));
	assign sub_v   = full ? SUM_W'($signed(old_rd)) : SUM_W'(0);
	assign sum_nxt = sum_q + SUM_W'(sample_q) - sub_v;
	assign mag     = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	assign trial   = {rem_q, dvd_q[DIV_W-1]};
	assign ge      = (trial >= {1'b0, count_q});
	assign diff    = trial - {1'b0, count_q};
	assign quo_res = neg_q ? (~dvd_q + DIV_W'(1)) : dvd_q;

	assign sts.div_last = (step_q == STEP_W'(DIV_W - 1));
	assign sts.out_free = !out_valid_q || avg_ready;
	assign avg_valid    = out_valid_q;
	assign average      = avg_q;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			sample_q <= sample;
		end
		if (cmd.prep) begin
			neg_q <= sum_q[SUM_W-1];
			dvd_q <= {mag, FRAC_W'(0)};
			rem_q <= '0;
		end else if (cmd.step) begin
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
		if (cmd.finish) begin
			avg_q <= quo_res[AVG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			slot_q      <= '0;
			count_q     <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				sum_q  <= sum_nxt;
				slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
				if (!full) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.prep) begin
				step_q <= '0;
			end else if (cmd.step) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (avg_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WINDOW))
		else $error("fill count beyond window");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SLOT_W'(WINDOW - 1))
		else $error("write slot beyond window");

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (rem_q < count_q))
		else $error("divider remainder not below count");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> (count_q != '0))
		else $error("zero divisor after update");

endmodule
